// ===== design/ntc_pkg.sv =====
// Shared types and constants for the NTC temperature channel.
package ntc_pkg;

    localparam int ADC_BITS  = 12;
    localparam int FRAC_BITS = 8;

    localparam int unsigned LN2_Q30 = 744261118;

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_LOGI  = 10'b0000000010,
        ST_LOGF  = 10'b0000000100,
        ST_ACC   = 10'b0000001000,
        ST_LN    = 10'b0000010000,
        ST_DIV   = 10'b0000100000,
        ST_CONV  = 10'b0001000000,
        ST_FILT  = 10'b0010000000,
        ST_OUT   = 10'b0100000000,
        ST_CLAMP = 10'b1000000000
    } state_t;

    typedef enum logic [1:0] {
        REG_SERIES  = 2'd0,
        REG_NOMINAL = 2'd1,
        REG_BETA    = 2'd2,
        REG_WEIGHT  = 2'd3
    } reg_idx_t;

endpackage

// ===== design/ntc_adc_to_temperature_filtered_unit.sv =====
// Top level of the NTC thermistor temperature channel with low-pass filter.
// Per request: four log2 passes on one shared squaring multiplier, a restoring divider,
// then clamp, filter and output steps.
// One request at a time; the next is accepted in the cycle after the result leaves.
// A full-scale sample skips to the output step, a zero sample or zero register to the filter step.
// Reset: registers return to 10000/10000/3950/6554 and the filter state to 25.0 C.
module ntc_adc_to_temperature_filtered_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [11:0]        adc_sample,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] temperature,
    output logic               limited
);

    localparam int ADC_BITS  = ntc_pkg::ADC_BITS;
    localparam int FRAC_BITS = ntc_pkg::FRAC_BITS;

    localparam logic [ADC_BITS-1:0] ADC_FULL = {ADC_BITS{1'b1}};
    localparam longint AZ_Q   = (27315 * (64'sd1 <<< FRAC_BITS) + 50) / 100;
    localparam longint TLOW_Q = -(40 * (64'sd1 <<< FRAC_BITS));
    localparam longint THI_Q  = 120 * (64'sd1 <<< FRAC_BITS);
    localparam int     DW     = 16 + FRAC_BITS + 14;
    localparam longint BQ_MUL = (64'sd6553600 * (64'sd1 <<< 29) + 64'sd29814) / 64'sd29815;
    localparam logic signed [DW:0] TC_LOW  = (DW+1)'(TLOW_Q);
    localparam logic signed [DW:0] TC_HIGH = (DW+1)'(THI_Q);

    logic [19:0] series_reg, nominal_reg;
    logic [13:0] beta_reg;
    logic [15:0] weight_reg;
    logic [1:0]  ridx;

    ntc_pkg::state_t state_reg, state_next;

    logic [ADC_BITS-1:0] adc_reg;
    logic [1:0]          op_reg;
    logic [5:0]          cnt_reg;
    logic [19:0]         lx;
    logic [4:0]          p_reg;
    logic [31:0]         m_reg;
    logic [15:0]         frac_reg;
    logic signed [31:0]  s_reg;
    logic signed [31:0]  den_reg;
    logic [DW-1:0]       quo_reg, rem_reg;
    logic signed [31:0]  temp_reg;
    logic                lim_reg;
    logic signed [25:0]  y_reg;
    logic signed [15:0]  tout_reg;
    logic                lout_reg;
    logic                ov_reg;
    logic                special;

    assign pready = 1'b1;
    assign ridx   = paddr[3:2];

    always_comb
    begin
        case (ridx)
            ntc_pkg::REG_SERIES:  prdata = {12'd0, series_reg};
            ntc_pkg::REG_NOMINAL: prdata = {12'd0, nominal_reg};
            ntc_pkg::REG_BETA:    prdata = {18'd0, beta_reg};
            ntc_pkg::REG_WEIGHT:  prdata = {16'd0, weight_reg};
            default:              prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            series_reg  <= 20'd10000;
            nominal_reg <= 20'd10000;
            beta_reg    <= 14'd3950;
            weight_reg  <= 16'd6554;
        end
        else if (psel && penable && pwrite)
        begin
            case (ridx)
                ntc_pkg::REG_SERIES:  series_reg  <= pwdata[19:0];
                ntc_pkg::REG_NOMINAL: nominal_reg <= pwdata[19:0];
                ntc_pkg::REG_BETA:    beta_reg    <= pwdata[13:0];
                ntc_pkg::REG_WEIGHT:  weight_reg  <= pwdata[15:0];
                default:              ;
            endcase
        end
    end

    assign in_stall  = (state_reg != ntc_pkg::ST_IDLE) || ov_reg;
    assign out_valid = ov_reg;
    assign temperature = tout_reg;
    assign limited     = lout_reg;

    // log2 operand selection
    always_comb
    begin
        case (op_reg)
            2'd0:    lx = series_reg;
            2'd1:    lx = 20'(ADC_FULL - adc_reg);
            2'd2:    lx = 20'(adc_reg);
            default: lx = nominal_reg;
        endcase
    end

    logic [63:0] sq;
    logic [31:0] msq;
    logic        msb_top;
    logic [4:0]  ptop;
    logic signed [31:0] lg;
    logic signed [63:0] lnprod;
    logic signed [31:0] lnr;
    logic [31:0] bq;
    logic [DW:0] rtrial;
    logic signed [DW:0] tc;
    logic signed [25:0] xs;
    logic signed [26:0] dif;
    logic signed [43:0] wprod;
    logic signed [25:0] ynew;

    assign sq  = {32'd0, m_reg} * {32'd0, m_reg};
    assign msq = sq[61:30];
    assign msb_top = msq[31];

    always_comb
    begin
        ptop = 5'd0;
        for (int i = 0; i < 20; i++)
            if (lx[i])
                ptop = 5'(i);
    end

    assign lg = $signed({11'd0, p_reg, frac_reg});
    assign lnprod = 64'(s_reg) * 64'sd744261118 + 64'sd536870912;
    assign lnr = 32'(lnprod >>> 30);
    assign bq = 32'((64'(beta_reg) * 64'(BQ_MUL)) >> 29);
    assign rtrial = {rem_reg, quo_reg[DW-1]} - {1'b0, DW'(den_reg)};
    assign tc = $signed({1'b0, quo_reg}) - (DW+1)'(AZ_Q);
    assign xs = 26'(temp_reg <<< 8);
    assign dif = 27'(xs) - 27'(y_reg);
    assign wprod = 44'(dif) * $signed({28'd0, weight_reg}) + 44'sd32768;
    assign ynew = y_reg + 26'(wprod >>> 16);
    assign special = (adc_reg == '0) || (series_reg == '0) || (nominal_reg == '0)
                   || (beta_reg == '0);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ntc_pkg::ST_IDLE: if (in_valid && !ov_reg) state_next = ntc_pkg::ST_LOGI;
            ntc_pkg::ST_LOGI:
                if (adc_reg == ADC_FULL) state_next = ntc_pkg::ST_OUT;
                else if (special)        state_next = ntc_pkg::ST_FILT;
                else                     state_next = ntc_pkg::ST_LOGF;
            ntc_pkg::ST_LOGF: if (cnt_reg == 6'd15) state_next = ntc_pkg::ST_ACC;
            ntc_pkg::ST_ACC:
                state_next = (op_reg == 2'd3) ? ntc_pkg::ST_LN : ntc_pkg::ST_LOGI;
            ntc_pkg::ST_LN:   state_next = ntc_pkg::ST_CONV;
            ntc_pkg::ST_CONV:
                if (den_reg <= 0) state_next = ntc_pkg::ST_FILT;
                else              state_next = ntc_pkg::ST_DIV;
            ntc_pkg::ST_DIV:
                if (cnt_reg == 6'(DW - 1)) state_next = ntc_pkg::ST_CLAMP;
            ntc_pkg::ST_CLAMP: state_next = ntc_pkg::ST_FILT;
            ntc_pkg::ST_FILT: state_next = ntc_pkg::ST_OUT;
            ntc_pkg::ST_OUT:  state_next = ntc_pkg::ST_IDLE;
            default:          state_next = ntc_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ntc_pkg::ST_IDLE;
            ov_reg       <= 1'b0;
            y_reg        <= 26'sd25 <<< (FRAC_BITS + 8);
            op_reg       <= 2'd0;
            cnt_reg      <= 6'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (ov_reg && !out_stall)
                ov_reg <= 1'b0;
            case (state_reg)
                ntc_pkg::ST_IDLE:
                begin
                    if (in_valid && !ov_reg)
                        adc_reg <= adc_sample[ADC_BITS-1:0];
                    op_reg   <= 2'd0;
                    s_reg    <= '0;
                    lim_reg  <= 1'b0;
                end
                ntc_pkg::ST_LOGI:
                begin
                    p_reg    <= ptop;
                    m_reg    <= 32'(lx) << (5'd30 - ptop);
                    frac_reg <= '0;
                    cnt_reg  <= '0;
                    temp_reg <= 32'(TLOW_Q);
                    lim_reg  <= 1'b1;
                end
                ntc_pkg::ST_LOGF:
                begin
                    m_reg    <= msb_top ? (msq >> 1) : msq;
                    frac_reg <= {frac_reg[14:0], msb_top};
                    cnt_reg  <= cnt_reg + 6'd1;
                end
                ntc_pkg::ST_ACC:
                begin
                    s_reg  <= (op_reg == 2'd0 || op_reg == 2'd1) ? s_reg + lg : s_reg - lg;
                    op_reg <= op_reg + 2'd1;
                end
                ntc_pkg::ST_LN:
                    den_reg <= $signed(bq) + lnr;
                ntc_pkg::ST_CONV:
                begin
                    lim_reg  <= 1'b1;
                    temp_reg <= (den_reg == 0) ? 32'(THI_Q) : 32'(TLOW_Q);
                    quo_reg  <= DW'(beta_reg) << (16 + FRAC_BITS);
                    rem_reg  <= '0;
                    cnt_reg  <= '0;
                end
                ntc_pkg::ST_DIV:
                begin
                    if (!rtrial[DW])
                    begin
                        rem_reg <= rtrial[DW-1:0];
                        quo_reg <= {quo_reg[DW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= {rem_reg[DW-2:0], quo_reg[DW-1]};
                        quo_reg <= {quo_reg[DW-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 6'd1;
                end
                ntc_pkg::ST_CLAMP:
                begin
                    lim_reg  <= (tc < TC_LOW) || (tc > TC_HIGH);
                    temp_reg <= (tc < TC_LOW) ? 32'(TLOW_Q) :
                                (tc > TC_HIGH) ? 32'(THI_Q) : 32'(tc);
                end
                ntc_pkg::ST_FILT:
                    y_reg <= ynew;
                ntc_pkg::ST_OUT:
                begin
                    ov_reg <= 1'b1;
                    if (adc_reg == ADC_FULL)
                    begin
                        tout_reg <= 16'(TLOW_Q);
                        lout_reg <= 1'b1;
                    end
                    else
                    begin
                        tout_reg <= 16'((27'(y_reg) + 27'sd128) >>> 8);
                        lout_reg <= lim_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ntc_pkg::ST_IDLE) |-> in_stall)
        else $error("request accepted while busy");
    a_out_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ov_reg) |-> $past(state_reg == ntc_pkg::ST_OUT))
        else $error("result raised outside output step");
    a_full_scale: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && adc_reg == ADC_FULL) |-> lout_reg)
        else $error("full-scale sample not flagged");

endmodule
